// ===== hw/rtl/vg3_pkg.sv =====
// vg3_pkg: shared types, constants and helper functions of the 3-D gradient block.
// Used by all design modules but vg3_checker; depends on nothing else.
`default_nettype none

package vg3_pkg;

   // default store dimensions
   localparam int MAX_X_DEF = 128;
   localparam int MAX_Y_DEF = 128;
   localparam int MAX_Z_DEF = 128;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int SIZE_W      = 8;
   localparam int INV_W       = 24;
   localparam int CFG_INDEX_W = 3;
   localparam int CFG_DATA_W  = 24;
   localparam int POS_W       = 7;
   localparam int GRAD_W      = 36;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int PROD_W      = DIFF_W + INV_W + 1;

   // result queue depth, also the number of results allowed in flight or queued
   localparam int QDEPTH = 8;

   // register reset values
   localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;
   localparam logic [INV_W-1:0]  INV_RESET  = 24'd65536;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_SIZE_X        = 3'd0,
      REG_SIZE_Y        = 3'd1,
      REG_SIZE_Z        = 3'd2,
      REG_INV_SPACING_X = 3'd3,
      REG_INV_SPACING_Y = 3'd4,
      REG_INV_SPACING_Z = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [INV_W-1:0] inv_x;
      logic [INV_W-1:0] inv_y;
      logic [INV_W-1:0] inv_z;
   } cfg_inv_type;

   // one classified request with its store reads, front to back
   typedef struct packed {
      logic                valid;
      logic                samp_mode;
      logic                c_zero;
      logic                half_x;
      logic                half_y;
      logic [SAMPLE_W-1:0] smp;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [POS_W-1:0]    pos_z;
      logic                last;
      logic [SAMPLE_W-1:0] rd_xp;
      logic [SAMPLE_W-1:0] rd_xm;
      logic [SAMPLE_W-1:0] rd_yp;
      logic [SAMPLE_W-1:0] rd_ym;
      logic [SAMPLE_W-1:0] rd_cc;
      logic [SAMPLE_W-1:0] rd_cm;
   } front_out_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic signed [GRAD_W-1:0] grad_z;
      logic [POS_W-1:0]         pos_x;
      logic [POS_W-1:0]         pos_y;
      logic [POS_W-1:0]         pos_z;
      logic                     volume_end;
   } result_type;

   // clamp a size register to 2..max
   function automatic int eff_size(input logic [SIZE_W-1:0] v, input int max);
      int r;
      if (int'(v) < 2) begin
         r = 2;
      end else if (int'(v) > max) begin
         r = max;
      end else begin
         r = int'(v);
      end
      return r;
   endfunction

   // drop to 8 fraction bits (floor; halved if half), then saturate to GRAD_W bits
   function automatic logic signed [GRAD_W-1:0] scale(input logic signed [PROD_W-1:0] p,
                                                      input logic half);
      logic signed [PROD_W-1:0] q;
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(64'sd34359738367);
      lo = PROD_W'(-64'sd34359738368);
      q  = half ? (p >>> 9) : (p >>> 8);
      if (q > hi) begin
         q = hi;
      end else if (q < lo) begin
         q = lo;
      end
      return q[GRAD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vg3_front.sv =====
// vg3_front: configuration registers, raster counters, request classification,
// two-plane store (three copies, two read ports each) and the credit count.
// Depends on vg3_pkg.
`default_nettype none

module vg3_front import vg3_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF,
   parameter int MAX_Z = MAX_Z_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CFG_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   input  wire logic                   req_cmd,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   output logic                        req_stall,
   input  wire logic                   pop,
   output front_out_type               front_out,
   output cfg_inv_type                 cfg_inv
);

   localparam int XW    = $clog2(MAX_X);
   localparam int YW    = $clog2(MAX_Y);
   localparam int SXW   = $clog2(MAX_X + 1);
   localparam int SYW   = $clog2(MAX_Y + 1);
   localparam int ZW    = $clog2(MAX_Z + 1);
   localparam int PLANE = MAX_X * MAX_Y;
   localparam int DEPTH = 2 * PLANE;
   localparam int AW    = $clog2(DEPTH);
   localparam int UW    = $clog2(QDEPTH + 1);

   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [INV_W-1:0]  inv_x_ff, inv_y_ff, inv_z_ff;
   logic [XW-1:0]     x_ff;
   logic [YW-1:0]     y_ff;
   logic [ZW-1:0]     z_ff;
   logic              full_ff;
   logic [UW-1:0]     used_ff;

   logic [SXW-1:0] sx, x_nx;
   logic [SYW-1:0] sy, y_nx;
   logic [ZW-1:0]  sz, z_nx, c;
   logic           full_now, accept, is_sample, is_drain, emits, last;
   logic           x_wrap, y_wrap, x_first, x_lastp, y_first, y_lastp;
   logic [XW-1:0]  xp, xm;
   logic [YW-1:0]  yp, ym;
   logic [AW-1:0]  a_xp, a_xm, a_yp, a_ym, a_cc, a_cm, a_wr;
   logic           we;
   logic [XW+POS_W-1:0] x_wide;
   logic [YW+POS_W-1:0] y_wide;
   logic [ZW+POS_W-1:0] c_wide;

   logic [SAMPLE_W-1:0] mem_a [DEPTH];
   logic [SAMPLE_W-1:0] mem_b [DEPTH];
   logic [SAMPLE_W-1:0] mem_c [DEPTH];

   front_out_type s1_ff, s1_in;

   function automatic logic [AW-1:0] addr(input logic slot, input logic [XW-1:0] xx,
                                          input logic [YW-1:0] yy);
      return AW'(slot) * AW'(PLANE) + AW'(yy) * AW'(MAX_X) + AW'(xx);
   endfunction

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
         inv_x_ff  <= INV_RESET;
         inv_y_ff  <= INV_RESET;
         inv_z_ff  <= INV_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SIZE_X:        size_x_ff <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Y:        size_y_ff <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Z:        size_z_ff <= csr_wdata[SIZE_W-1:0];
            REG_INV_SPACING_X: inv_x_ff  <= csr_wdata[INV_W-1:0];
            REG_INV_SPACING_Y: inv_y_ff  <= csr_wdata[INV_W-1:0];
            REG_INV_SPACING_Z: inv_z_ff  <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg_inv = '{inv_x: inv_x_ff, inv_y: inv_y_ff, inv_z: inv_z_ff};

   // classify the request and work out the store addresses
   always_comb begin
      sx = SXW'(eff_size(size_x_ff, MAX_X));
      sy = SYW'(eff_size(size_y_ff, MAX_Y));
      sz = ZW'(eff_size(size_z_ff, MAX_Z));

      req_stall = (used_ff == UW'(QDEPTH));
      accept    = req_valid & ~req_stall;
      full_now  = full_ff | (z_ff >= sz);
      is_sample = ~full_now & (req_cmd == CMD_SAMPLE);
      is_drain  = full_now;
      emits     = accept & ((is_sample & (z_ff != '0)) | is_drain);
      c         = (z_ff != '0) ? z_ff - ZW'(1) : '0;

      x_nx   = SXW'(x_ff) + SXW'(1);
      y_nx   = SYW'(y_ff) + SYW'(1);
      z_nx   = z_ff + ZW'(1);
      x_wrap = (x_nx >= sx);
      y_wrap = (y_nx >= sy);
      last   = is_drain & x_wrap & y_wrap;

      // neighbours: forward at the first voxel, backward at the last
      x_first = (x_ff == '0);
      x_lastp = (SXW'(x_ff) >= sx - SXW'(1));
      y_first = (y_ff == '0);
      y_lastp = (SYW'(y_ff) >= sy - SYW'(1));
      xp = (x_lastp & ~x_first) ? x_ff : x_ff + XW'(1);
      xm = x_first ? x_ff : x_ff - XW'(1);
      yp = (y_lastp & ~y_first) ? y_ff : y_ff + YW'(1);
      ym = y_first ? y_ff : y_ff - YW'(1);

      a_xp = addr(c[0], xp, y_ff);
      a_xm = addr(c[0], xm, y_ff);
      a_yp = addr(c[0], x_ff, yp);
      a_ym = addr(c[0], x_ff, ym);
      a_cc = addr(c[0], x_ff, y_ff);
      a_cm = addr(~c[0], x_ff, y_ff);
      a_wr = addr(z_ff[0], x_ff, y_ff);
      we   = accept & is_sample;

      x_wide = {POS_W'(0), x_ff};
      y_wide = {POS_W'(0), y_ff};
      c_wide = {POS_W'(0), c};

      s1_in           = s1_ff;
      s1_in.valid     = emits;
      s1_in.samp_mode = is_sample;
      s1_in.c_zero    = (c == '0);
      s1_in.half_x    = ~x_first & ~x_lastp;
      s1_in.half_y    = ~y_first & ~y_lastp;
      s1_in.smp       = req_sample;
      s1_in.pos_x     = x_wide[POS_W-1:0];
      s1_in.pos_y     = y_wide[POS_W-1:0];
      s1_in.pos_z     = c_wide[POS_W-1:0];
      s1_in.last      = last;
   end

   // advance the raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         full_ff <= 1'b0;
      end else if (accept) begin
         if (is_sample) begin
            x_ff <= x_wrap ? '0 : x_nx[XW-1:0];
            if (x_wrap) begin
               y_ff <= y_wrap ? '0 : y_nx[YW-1:0];
               if (y_wrap) begin
                  z_ff <= z_nx;
                  if (z_nx >= sz) begin
                     full_ff <= 1'b1;
                  end
               end
            end
         end else if (is_drain) begin
            if (last) begin
               x_ff    <= '0;
               y_ff    <= '0;
               z_ff    <= '0;
               full_ff <= 1'b0;
            end else begin
               full_ff <= 1'b1;
               x_ff    <= x_wrap ? '0 : x_nx[XW-1:0];
               if (x_wrap) begin
                  y_ff <= y_nx[YW-1:0];
               end
            end
         end
      end
   end

   // store copies: write the sample, read old contents first, and hold the
   // classified request beside its reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_a[a_wr] <= req_sample;
         mem_b[a_wr] <= req_sample;
         mem_c[a_wr] <= req_sample;
      end
      s1_ff.rd_xp <= mem_a[a_xp];
      s1_ff.rd_xm <= mem_a[a_xm];
      s1_ff.rd_yp <= mem_b[a_yp];
      s1_ff.rd_ym <= mem_b[a_ym];
      s1_ff.rd_cc <= mem_c[a_cc];
      s1_ff.rd_cm <= mem_c[a_cm];
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.samp_mode <= s1_in.samp_mode;
      s1_ff.c_zero    <= s1_in.c_zero;
      s1_ff.half_x    <= s1_in.half_x;
      s1_ff.half_y    <= s1_in.half_y;
      s1_ff.smp       <= s1_in.smp;
      s1_ff.pos_x     <= s1_in.pos_x;
      s1_ff.pos_y     <= s1_in.pos_y;
      s1_ff.pos_z     <= s1_in.pos_z;
      s1_ff.last      <= s1_in.last;
   end

   assign front_out = s1_ff;

   // count results in flight or queued
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_ff + UW'(emits) - UW'(pop);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vg3_back.sv =====
// vg3_back: differences, scaling by reciprocal spacing, floor and saturation.
// Two register stages; depends on vg3_pkg.
`default_nettype none

module vg3_back import vg3_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  front_out_type      front_out,
   input  cfg_inv_type        cfg_inv,
   output logic               res_valid,
   output result_type         res
);

   logic                     a_valid_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic                     hx_a_ff, hy_a_ff, hz_a_ff;
   logic [POS_W-1:0]         px_a_ff, py_a_ff, pz_a_ff;
   logic                     last_a_ff;

   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic [SAMPLE_W-1:0]      zref;

   logic                     b_valid_ff;
   logic signed [PROD_W-1:0] prx_ff, pry_ff, prz_ff;
   logic                     hx_b_ff, hy_b_ff, hz_b_ff;
   logic [POS_W-1:0]         px_b_ff, py_b_ff, pz_b_ff;
   logic                     last_b_ff;

   // form the three differences
   always_comb begin
      zref  = front_out.c_zero ? front_out.rd_cc : front_out.rd_cm;
      dx_in = $signed({1'b0, front_out.rd_xp}) - $signed({1'b0, front_out.rd_xm});
      dy_in = $signed({1'b0, front_out.rd_yp}) - $signed({1'b0, front_out.rd_ym});
      if (front_out.samp_mode) begin
         dz_in = $signed({1'b0, front_out.smp}) - $signed({1'b0, zref});
      end else begin
         dz_in = $signed({1'b0, front_out.rd_cc}) - $signed({1'b0, front_out.rd_cm});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= front_out.valid;
      end
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      hx_a_ff   <= front_out.half_x;
      hy_a_ff   <= front_out.half_y;
      hz_a_ff   <= front_out.samp_mode & ~front_out.c_zero;
      px_a_ff   <= front_out.pos_x;
      py_a_ff   <= front_out.pos_y;
      pz_a_ff   <= front_out.pos_z;
      last_a_ff <= front_out.last;
   end

   // multiply by the reciprocal spacing of each axis
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      prx_ff    <= dx_ff * $signed({1'b0, cfg_inv.inv_x});
      pry_ff    <= dy_ff * $signed({1'b0, cfg_inv.inv_y});
      prz_ff    <= dz_ff * $signed({1'b0, cfg_inv.inv_z});
      hx_b_ff   <= hx_a_ff;
      hy_b_ff   <= hy_a_ff;
      hz_b_ff   <= hz_a_ff;
      px_b_ff   <= px_a_ff;
      py_b_ff   <= py_a_ff;
      pz_b_ff   <= pz_a_ff;
      last_b_ff <= last_a_ff;
   end

   // drop fraction bits and saturate
   always_comb begin
      res_valid      = b_valid_ff;
      res.grad_x     = scale(prx_ff, hx_b_ff);
      res.grad_y     = scale(pry_ff, hy_b_ff);
      res.grad_z     = scale(prz_ff, hz_b_ff);
      res.pos_x      = px_b_ff;
      res.pos_y      = py_b_ff;
      res.pos_z      = pz_b_ff;
      res.volume_end = last_b_ff;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vg3_queue.sv =====
// vg3_queue: short result queue between the arithmetic and the response port.
// Depends on vg3_pkg; never overflows since the front limits results in flight.
`default_nettype none

module vg3_queue import vg3_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  result_type  push_data,
   input  wire logic   pop,
   output logic        out_valid,
   output result_type  out_data
);

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   result_type     slot_ff [QDEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [CW-1:0]  count_ff;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ff];

   // store pushed results
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(QDEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/volume_gradient_3d.sv =====
// volume_gradient_3d: top level of the streaming 3-D central-difference gradient.
// Instantiates vg3_front, vg3_back and vg3_queue; depends on vg3_pkg.
//
// Voxel samples enter in raster order (x fastest) at one request per clock unless
// stalled; the gradient of voxel (x,y,z) leaves once the sample at (x,y,z+1) is
// taken, and the last plane is flushed by drain requests. Each request passes from
// acceptance to the response port through the store read, the differences, the
// multiply and the result queue, each registered. The sustained rate is one request
// per cycle unless stalled, set by the plane store, which is kept as three copies
// with two read ports each so that all six neighbour reads happen in the acceptance
// cycle. Up to eight results may be outstanding; beyond that req_stall rises until
// the response side takes one. The store needs no clearing after reset.
`default_nettype none

module volume_gradient_3d import vg3_pkg::*; #(
   parameter int MAX_X = MAX_X_DEF,
   parameter int MAX_Y = MAX_Y_DEF,
   parameter int MAX_Z = MAX_Z_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CFG_INDEX_W-1:0]   csr_index,
   input  wire logic [CFG_DATA_W-1:0]    csr_wdata,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_cmd,
   input  wire logic [SAMPLE_W-1:0]      req_sample,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [GRAD_W-1:0]      rsp_grad_x,
   output logic signed [GRAD_W-1:0]      rsp_grad_y,
   output logic signed [GRAD_W-1:0]      rsp_grad_z,
   output logic [POS_W-1:0]              rsp_pos_x,
   output logic [POS_W-1:0]              rsp_pos_y,
   output logic [POS_W-1:0]              rsp_pos_z,
   output logic                          rsp_volume_end
);

   front_out_type front_out;
   cfg_inv_type   cfg_inv;
   result_type    res, out_data;
   logic          res_valid, pop;

   // registers are always writable
   assign csr_ready = 1'b1;
   assign pop       = rsp_valid & ~rsp_stall;

   vg3_front #(
      .MAX_X(MAX_X),
      .MAX_Y(MAX_Y),
      .MAX_Z(MAX_Z)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_cmd    (req_cmd),
      .req_sample (req_sample),
      .req_stall  (req_stall),
      .pop        (pop),
      .front_out  (front_out),
      .cfg_inv    (cfg_inv)
   );

   vg3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .front_out (front_out),
      .cfg_inv   (cfg_inv),
      .res_valid (res_valid),
      .res       (res)
   );

   vg3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   // unpack the queue head onto the response port
   assign rsp_grad_x     = out_data.grad_x;
   assign rsp_grad_y     = out_data.grad_y;
   assign rsp_grad_z     = out_data.grad_z;
   assign rsp_pos_x      = out_data.pos_x;
   assign rsp_pos_y      = out_data.pos_y;
   assign rsp_pos_z      = out_data.pos_z;
   assign rsp_volume_end = out_data.volume_end;

endmodule

`default_nettype wire

// ===== hw/rtl/vg3_checker.sv =====
// vg3_checker: port-level assertions for volume_gradient_3d, and its bind.
// Depends on the top level's port names only.
`default_nettype none

module vg3_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [35:0] rsp_grad_x,
   input wire logic [35:0] rsp_grad_y,
   input wire logic [35:0] rsp_grad_z,
   input wire logic        rsp_volume_end
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_grad_x) && $stable(rsp_grad_y)
         && $stable(rsp_grad_z) && $stable(rsp_volume_end))
      else $error("stalled response changed");

   // reset empties the queue and frees every credit
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // request stall only while results are waiting at the port
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("request stalled with empty result queue");

endmodule

bind volume_gradient_3d vg3_checker u_vg3_checker (.*);

`default_nettype wire
